// ===== hdl/ssmd_pkg.sv =====
// Shared types, codes and the segment table for the seven-segment mode display.
`timescale 1ns / 1ps

package ssmd_pkg;

    typedef logic [4:0] code_t;
    typedef logic [7:0] seg_t;

    typedef struct packed {
        logic        command;
        logic [2:0]  display_mode;
        logic [6:0]  voltage;
        logic [16:0] frequency;
        logic [6:0]  temp_whole;
        logic [6:0]  temp_fraction;
        logic [6:0]  threshold;
    } request_t;

    typedef struct packed {
        logic [7:0] digit_enable;
        logic [7:0] segment_bits;
    } result_t;

    localparam logic CMD_REFRESH = 1'b0;
    localparam logic CMD_SCAN    = 1'b1;

    localparam logic [2:0] MODE_KEEP       = 3'd0;
    localparam logic [2:0] MODE_VOLT       = 3'd1;
    localparam logic [2:0] MODE_FREQ       = 3'd2;
    localparam logic [2:0] MODE_TEMP       = 3'd3;
    localparam logic [2:0] MODE_THRESH     = 3'd4;
    localparam logic [2:0] MODE_RCL_VOLT   = 3'd5;
    localparam logic [2:0] MODE_RCL_FREQ   = 3'd6;
    localparam logic [2:0] MODE_RCL_TEMP   = 3'd7;

    localparam code_t CODE_T     = 5'd12;  // drawn as C
    localparam code_t CODE_F     = 5'd15;
    localparam code_t CODE_BLANK = 5'd16;
    localparam code_t CODE_U     = 5'd18;
    localparam code_t CODE_H     = 5'd19;
    localparam code_t CODE_P     = 5'd20;

    localparam logic [6:0]  SAT_TWO  = 7'd99;
    localparam logic [16:0] SAT_FREQ = 17'd99999;

    // floor(x / 1000) == (x * FREQ_RECIP) >> FREQ_SHIFT for x up to 99999
    localparam logic [34:0] FREQ_RECIP = 35'd134218;
    localparam int          FREQ_SHIFT = 27;

    localparam seg_t SEG_DARK = 8'hff;
    localparam seg_t DP_MASK  = 8'h7f;

    function automatic seg_t seg_of(input code_t code);
        seg_t s;
        unique case (code)
            5'd0:    s = 8'hc0;
            5'd1:    s = 8'hf9;
            5'd2:    s = 8'ha4;
            5'd3:    s = 8'hb0;
            5'd4:    s = 8'h99;
            5'd5:    s = 8'h92;
            5'd6:    s = 8'h82;
            5'd7:    s = 8'hf8;
            5'd8:    s = 8'h80;
            5'd9:    s = 8'h90;
            5'd10:   s = 8'h88;
            5'd11:   s = 8'h83;
            5'd12:   s = 8'hc6;
            5'd13:   s = 8'ha1;
            5'd14:   s = 8'h86;
            5'd15:   s = 8'h8e;
            5'd16:   s = 8'hff;
            5'd17:   s = 8'hbf;
            5'd18:   s = 8'hc1;
            5'd19:   s = 8'h89;
            5'd20:   s = 8'h8c;
            default: s = SEG_DARK;
        endcase
        return s;
    endfunction

    // tens digit of a value 0..99 by reciprocal multiply
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [13:0] p;
        p = {7'd0, v} * 14'd103;
        return p[13:10];
    endfunction

    // hundreds digit of a value 0..999
    function automatic logic [3:0] div100(input logic [9:0] v);
        logic [15:0] p;
        p = {6'd0, v} * 16'd41;
        return p[15:12];
    endfunction

endpackage

// ===== hdl/seven_segment_mode_display.sv =====
// Top level of the eight-digit multiplexed seven-segment display driver.
`timescale 1ns / 1ps

// Accepts one request per clock while request_stall is low. A refresh
// request (command 0) rebuilds the eight digit codes and the segment buffer
// from the display mode and values; a scan request (command 1) returns the
// one-hot enable and segment byte of the next digit. Requests pass through
// three internal stages in order (input capture, divide of the frequency by
// 1000 through a reciprocal multiply, remainder and digit split) before they
// update the buffer or load the result register, so a scan result always
// reflects every earlier refresh. A held result does not block refreshes
// behind it. Control and display state reset; payload registers do not.
module seven_segment_mode_display
(
    input  logic              clk,
    input  logic              rst_n,
    input  ssmd_pkg::request_t request,
    input  logic              request_valid,
    output logic              request_stall,
    output ssmd_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);

    // stage 1: captured request
    logic               s1_valid_reg;
    ssmd_pkg::request_t s1_req_reg;

    // stage 2: saturated values and frequency / 1000
    logic        s2_valid_reg;
    logic        s2_cmd_reg;
    logic [2:0]  s2_mode_reg;
    logic [6:0]  s2_volt_reg, s2_tw_reg, s2_tf_reg, s2_th_reg;
    logic [16:0] s2_freq_reg;
    logic [6:0]  s2_hi_reg;

    // stage 3: frequency split into thousands and remainder
    logic        s3_valid_reg;
    logic        s3_cmd_reg;
    logic [2:0]  s3_mode_reg;
    logic [6:0]  s3_volt_reg, s3_tw_reg, s3_tf_reg, s3_th_reg;
    logic [6:0]  s3_hi_reg;
    logic [9:0]  s3_lo_reg;

    // display state
    ssmd_pkg::code_t digit_codes_reg [8];
    ssmd_pkg::seg_t  segment_buffer_reg [8];
    logic [2:0]      scan_pos_reg;

    logic              result_valid_reg;
    ssmd_pkg::result_t result_reg;

    logic out_free, s3_move, s3_free, s2_move, s2_free, s1_move, s1_free;

    assign out_free = !result_valid_reg || !result_stall;
    assign s3_move  = s3_valid_reg && (s3_cmd_reg == ssmd_pkg::CMD_REFRESH || out_free);
    assign s3_free  = !s3_valid_reg || s3_move;
    assign s2_move  = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;

    assign request_stall = !s1_free;
    assign result_valid  = result_valid_reg;
    assign result        = result_reg;

    // stage 2 logic
    logic [6:0]  sat_volt, sat_tw, sat_tf, sat_th;
    logic [16:0] sat_freq;
    logic [34:0] freq_prod;

    function automatic logic [6:0] sat_two(input logic [6:0] v);
        return (v > ssmd_pkg::SAT_TWO) ? ssmd_pkg::SAT_TWO : v;
    endfunction

    assign sat_volt = sat_two(s1_req_reg.voltage);
    assign sat_tw   = sat_two(s1_req_reg.temp_whole);
    assign sat_tf   = sat_two(s1_req_reg.temp_fraction);
    assign sat_th   = sat_two(s1_req_reg.threshold);
    assign sat_freq = (s1_req_reg.frequency > ssmd_pkg::SAT_FREQ) ?
                      ssmd_pkg::SAT_FREQ : s1_req_reg.frequency;
    assign freq_prod = {18'd0, sat_freq} * ssmd_pkg::FREQ_RECIP;

    // stage 3 logic
    logic [16:0] freq_rem;
    assign freq_rem = s2_freq_reg - ({10'd0, s2_hi_reg} * 17'd1000);

    // commit logic: digit split, layout, segment encode
    ssmd_pkg::code_t codes_next [8];
    ssmd_pkg::seg_t  seg_next [8];
    ssmd_pkg::code_t fd [8];
    logic [3:0]      v_t, v_u, w_t, w_u, f_t, f_u, h_t, h_u;
    logic [3:0]      q_t, q_u, q_h, r_t, r_u;
    logic [6:0]      lo_rem;

    always_comb
    begin
        v_t = ssmd_pkg::div10(s3_volt_reg);
        v_u = 4'(s3_volt_reg - 7'(v_t) * 7'd10);
        w_t = ssmd_pkg::div10(s3_tw_reg);
        w_u = 4'(s3_tw_reg - 7'(w_t) * 7'd10);
        f_t = ssmd_pkg::div10(s3_tf_reg);
        f_u = 4'(s3_tf_reg - 7'(f_t) * 7'd10);
        h_t = ssmd_pkg::div10(s3_th_reg);
        h_u = 4'(s3_th_reg - 7'(h_t) * 7'd10);
        q_t = ssmd_pkg::div10(s3_hi_reg);
        q_u = 4'(s3_hi_reg - 7'(q_t) * 7'd10);
        q_h = ssmd_pkg::div100(s3_lo_reg);
        lo_rem = 7'(s3_lo_reg - 10'(q_h) * 10'd100);
        r_t = ssmd_pkg::div10(lo_rem);
        r_u = 4'(lo_rem - 7'(r_t) * 7'd10);

        // frequency digits with leading zeros blanked through the tens digit
        for (int i = 0; i < 8; i++)
        begin
            fd[i] = ssmd_pkg::CODE_BLANK;
        end
        fd[3] = {1'b0, q_t};
        fd[4] = {1'b0, q_u};
        fd[5] = {1'b0, q_h};
        fd[6] = {1'b0, r_t};
        fd[7] = {1'b0, r_u};
        if (q_t == 4'd0)
        begin
            fd[3] = ssmd_pkg::CODE_BLANK;
            if (q_u == 4'd0)
            begin
                fd[4] = ssmd_pkg::CODE_BLANK;
                if (q_h == 4'd0)
                begin
                    fd[5] = ssmd_pkg::CODE_BLANK;
                    if (r_t == 4'd0)
                    begin
                        fd[6] = ssmd_pkg::CODE_BLANK;
                    end
                end
            end
        end

        for (int i = 0; i < 8; i++)
        begin
            codes_next[i] = (s3_mode_reg == ssmd_pkg::MODE_KEEP) ?
                            digit_codes_reg[i] : ssmd_pkg::CODE_BLANK;
        end

        unique case (s3_mode_reg)
            ssmd_pkg::MODE_VOLT, ssmd_pkg::MODE_RCL_VOLT:
            begin
                codes_next[6] = {1'b0, v_t};
                codes_next[7] = {1'b0, v_u};
            end
            ssmd_pkg::MODE_THRESH:
            begin
                codes_next[6] = {1'b0, h_t};
                codes_next[7] = {1'b0, h_u};
            end
            ssmd_pkg::MODE_FREQ, ssmd_pkg::MODE_RCL_FREQ:
            begin
                for (int i = 3; i < 8; i++)
                begin
                    codes_next[i] = fd[i];
                end
            end
            ssmd_pkg::MODE_TEMP, ssmd_pkg::MODE_RCL_TEMP:
            begin
                codes_next[4] = (w_t == 4'd0) ? ssmd_pkg::CODE_BLANK : {1'b0, w_t};
                codes_next[5] = {1'b0, w_u};
                codes_next[6] = {1'b0, f_t};
                codes_next[7] = {1'b0, f_u};
            end
            default:
            begin
            end
        endcase

        unique case (s3_mode_reg)
            ssmd_pkg::MODE_VOLT:     codes_next[0] = ssmd_pkg::CODE_U;
            ssmd_pkg::MODE_FREQ:     codes_next[0] = ssmd_pkg::CODE_F;
            ssmd_pkg::MODE_TEMP:     codes_next[0] = ssmd_pkg::CODE_T;
            ssmd_pkg::MODE_THRESH:   codes_next[0] = ssmd_pkg::CODE_P;
            ssmd_pkg::MODE_RCL_VOLT:
            begin
                codes_next[0] = ssmd_pkg::CODE_H;
                codes_next[1] = ssmd_pkg::CODE_U;
            end
            ssmd_pkg::MODE_RCL_FREQ:
            begin
                codes_next[0] = ssmd_pkg::CODE_H;
                codes_next[1] = ssmd_pkg::CODE_F;
            end
            ssmd_pkg::MODE_RCL_TEMP:
            begin
                codes_next[0] = ssmd_pkg::CODE_H;
                codes_next[1] = ssmd_pkg::CODE_T;
            end
            default:
            begin
            end
        endcase

        for (int i = 0; i < 8; i++)
        begin
            seg_next[i] = ssmd_pkg::seg_of(codes_next[i]);
        end

        if (s3_mode_reg == ssmd_pkg::MODE_VOLT || s3_mode_reg == ssmd_pkg::MODE_THRESH ||
            s3_mode_reg == ssmd_pkg::MODE_RCL_VOLT)
        begin
            seg_next[6] = seg_next[6] & ssmd_pkg::DP_MASK;
        end
        else if (s3_mode_reg == ssmd_pkg::MODE_TEMP || s3_mode_reg == ssmd_pkg::MODE_RCL_TEMP)
        begin
            seg_next[5] = seg_next[5] & ssmd_pkg::DP_MASK;
        end
    end

    // control and display state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            scan_pos_reg     <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                digit_codes_reg[i]    <= 5'd0;
                segment_buffer_reg[i] <= ssmd_pkg::SEG_DARK;
            end
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= request_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end

            if (s3_move && s3_cmd_reg == ssmd_pkg::CMD_SCAN)
            begin
                result_valid_reg <= 1'b1;
                scan_pos_reg     <= scan_pos_reg + 3'd1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (s3_move && s3_cmd_reg == ssmd_pkg::CMD_REFRESH)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    digit_codes_reg[i]    <= codes_next[i];
                    segment_buffer_reg[i] <= seg_next[i];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_free && request_valid)
        begin
            s1_req_reg <= request;
        end
        if (s1_move)
        begin
            s2_cmd_reg  <= s1_req_reg.command;
            s2_mode_reg <= s1_req_reg.display_mode;
            s2_volt_reg <= sat_volt;
            s2_tw_reg   <= sat_tw;
            s2_tf_reg   <= sat_tf;
            s2_th_reg   <= sat_th;
            s2_freq_reg <= sat_freq;
            s2_hi_reg   <= freq_prod[ssmd_pkg::FREQ_SHIFT +: 7];
        end
        if (s2_move)
        begin
            s3_cmd_reg  <= s2_cmd_reg;
            s3_mode_reg <= s2_mode_reg;
            s3_volt_reg <= s2_volt_reg;
            s3_tw_reg   <= s2_tw_reg;
            s3_tf_reg   <= s2_tf_reg;
            s3_th_reg   <= s2_th_reg;
            s3_hi_reg   <= s2_hi_reg;
            s3_lo_reg   <= freq_rem[9:0];
        end
        if (s3_move && s3_cmd_reg == ssmd_pkg::CMD_SCAN)
        begin
            result_reg.digit_enable <= 8'd1 << scan_pos_reg;
            result_reg.segment_bits <= segment_buffer_reg[scan_pos_reg];
        end
    end

endmodule

// ===== hdl/ssmd_checker.sv =====
// Port-level checks for the seven-segment mode display, bound to the top level.
`timescale 1ns / 1ps

module ssmd_checker
(
    input logic              clk,
    input logic              rst_n,
    input ssmd_pkg::request_t request,
    input logic              request_valid,
    input logic              request_stall,
    input ssmd_pkg::result_t result,
    input logic              result_valid,
    input logic              result_stall
);

    logic       have_last_reg;
    logic [7:0] last_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg <= 1'b0;
            last_en_reg   <= 8'd0;
        end
        else if (result_valid && !result_stall)
        begin
            have_last_reg <= 1'b1;
            last_en_reg   <= result.digit_enable;
        end
    end

    // a stalled request stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_stall |=> request_valid && $stable(request))
        else $error("stalled request changed");

    // a held result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("held result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot(result.digit_enable))
        else $error("digit enable not one-hot");

    // scan order walks the digits one by one, wrapping after digit 7
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && have_last_reg |->
            result.digit_enable == {last_en_reg[6:0], last_en_reg[7]})
        else $error("scan skipped or repeated a digit");

    // first scan after reset starts at digit 0
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !have_last_reg |-> result.digit_enable == 8'd1)
        else $error("scan did not start at digit 0");

endmodule

bind seven_segment_mode_display ssmd_checker u_ssmd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .request       (request),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .result        (result),
    .result_valid  (result_valid),
    .result_stall  (result_stall)
);

// ===== tb/tb_seven_segment_mode_display.sv =====
// Self-checking testbench for the seven-segment mode display driver.
`timescale 1ns / 1ps

module tb_seven_segment_mode_display;

    localparam int RANDOM_ITEMS = 700;
    localparam int LONG_HOLD    = 80;
    localparam int TIMEOUT_NS   = 3_000_000;

    typedef struct packed {
        bit                pinned;   // want holds a hand-typed result
        ssmd_pkg::result_t want;
    } pin_t;

    typedef struct packed {
        ssmd_pkg::request_t req;
        bit                 pinned;
        ssmd_pkg::result_t  want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    ssmd_pkg::request_t request;
    logic               request_valid;
    logic               request_stall;
    ssmd_pkg::result_t  result;
    logic               result_valid;
    logic               result_stall;

    // display state as predicted
    ssmd_pkg::code_t disp_codes [8];
    ssmd_pkg::seg_t  disp_segs [8];
    logic [2:0]      disp_pos;

    ssmd_pkg::seg_t glyph_rom [0:20] = '{
        8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8,
        8'h80, 8'h90, 8'h88, 8'h83, 8'hc6, 8'ha1, 8'h86, 8'h8e,
        8'hff, 8'hbf, 8'hc1, 8'h89, 8'h8c
    };

    ssmd_pkg::result_t scan_expect_q [$];
    pin_t              pin_q [$];
    dir_row_t          directed_rows [$];

    int  mismatches = 0;
    int  items_sent = 0;
    bit  no_idle = 1'b0;
    bit  long_hold_req = 1'b0;

    seven_segment_mode_display u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .result        (result),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %02h want %02h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [6:0] clip_two(input logic [6:0] v);
        return (v > ssmd_pkg::SAT_TWO) ? ssmd_pkg::SAT_TWO : v;
    endfunction

    function automatic void put_pair(input logic [6:0] v, input int pos);
        disp_codes[pos]     = ssmd_pkg::code_t'(v / 10);
        disp_codes[pos + 1] = ssmd_pkg::code_t'(v % 10);
    endfunction

    function automatic void put_freq(input logic [16:0] raw);
        logic [16:0] f;
        bit          lead;
        f = (raw > ssmd_pkg::SAT_FREQ) ? ssmd_pkg::SAT_FREQ : raw;
        disp_codes[3] = ssmd_pkg::code_t'(f / 10000);
        disp_codes[4] = ssmd_pkg::code_t'((f % 10000) / 1000);
        disp_codes[5] = ssmd_pkg::code_t'((f % 1000) / 100);
        disp_codes[6] = ssmd_pkg::code_t'((f % 100) / 10);
        disp_codes[7] = ssmd_pkg::code_t'(f % 10);
        // units digit always shows
        lead = 1'b1;
        for (int i = 3; i < 7; i++)
        begin
            if (lead && disp_codes[i] == 0)
                disp_codes[i] = ssmd_pkg::CODE_BLANK;
            else
                lead = 1'b0;
        end
    endfunction

    function automatic void put_temp(input logic [6:0] whole, input logic [6:0] frac);
        put_pair(clip_two(whole), 4);
        put_pair(clip_two(frac), 6);
        if (disp_codes[4] == 0)
            disp_codes[4] = ssmd_pkg::CODE_BLANK;
    endfunction

    // Applies one request to the predicted display; returns 1 when it yields a result.
    function automatic bit predict_display(input ssmd_pkg::request_t r,
                                           output ssmd_pkg::result_t res);
        res = '0;
        if (r.command == ssmd_pkg::CMD_SCAN)
        begin
            res.digit_enable = 8'd1 << disp_pos;
            res.segment_bits = disp_segs[disp_pos];
            disp_pos = disp_pos + 3'd1;
            return 1'b1;
        end
        if (r.display_mode != ssmd_pkg::MODE_KEEP)
            for (int i = 1; i < 8; i++)
                disp_codes[i] = ssmd_pkg::CODE_BLANK;
        case (r.display_mode)
            ssmd_pkg::MODE_VOLT:
            begin
                disp_codes[0] = ssmd_pkg::CODE_U;
                put_pair(clip_two(r.voltage), 6);
            end
            ssmd_pkg::MODE_FREQ:
            begin
                disp_codes[0] = ssmd_pkg::CODE_F;
                put_freq(r.frequency);
            end
            ssmd_pkg::MODE_TEMP:
            begin
                disp_codes[0] = ssmd_pkg::CODE_T;
                put_temp(r.temp_whole, r.temp_fraction);
            end
            ssmd_pkg::MODE_THRESH:
            begin
                disp_codes[0] = ssmd_pkg::CODE_P;
                put_pair(clip_two(r.threshold), 6);
            end
            ssmd_pkg::MODE_RCL_VOLT:
            begin
                disp_codes[0] = ssmd_pkg::CODE_H;
                disp_codes[1] = ssmd_pkg::CODE_U;
                put_pair(clip_two(r.voltage), 6);
            end
            ssmd_pkg::MODE_RCL_FREQ:
            begin
                disp_codes[0] = ssmd_pkg::CODE_H;
                disp_codes[1] = ssmd_pkg::CODE_F;
                put_freq(r.frequency);
            end
            ssmd_pkg::MODE_RCL_TEMP:
            begin
                disp_codes[0] = ssmd_pkg::CODE_H;
                disp_codes[1] = ssmd_pkg::CODE_T;
                put_temp(r.temp_whole, r.temp_fraction);
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
            disp_segs[i] = (disp_codes[i] < $size(glyph_rom)) ? glyph_rom[disp_codes[i]]
                                                               : ssmd_pkg::SEG_DARK;
        case (r.display_mode)
            ssmd_pkg::MODE_VOLT, ssmd_pkg::MODE_THRESH, ssmd_pkg::MODE_RCL_VOLT:
                disp_segs[6] &= ssmd_pkg::DP_MASK;
            ssmd_pkg::MODE_TEMP, ssmd_pkg::MODE_RCL_TEMP:
                disp_segs[5] &= ssmd_pkg::DP_MASK;
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic dir_row_t scan_row(input bit pinned, input logic [7:0] en,
                                          input ssmd_pkg::seg_t seg);
        dir_row_t row;
        row = '0;
        row.req.command = ssmd_pkg::CMD_SCAN;
        row.pinned = pinned;
        row.want.digit_enable = en;
        row.want.segment_bits = seg;
        return row;
    endfunction

    function automatic dir_row_t refresh_row(input logic [2:0] mode, input logic [6:0] volt,
                                             input logic [16:0] freq, input logic [6:0] tw,
                                             input logic [6:0] tf, input logic [6:0] th);
        dir_row_t row;
        row = '0;
        row.req.command = ssmd_pkg::CMD_REFRESH;
        row.req.display_mode = mode;
        row.req.voltage = volt;
        row.req.frequency = freq;
        row.req.temp_whole = tw;
        row.req.temp_fraction = tf;
        row.req.threshold = th;
        return row;
    endfunction

    function automatic logic [6:0] pick_two();
        return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 99));
    endfunction

    function automatic ssmd_pkg::request_t rand_scan();
        logic [63:0]        w;
        ssmd_pkg::request_t r;
        w = {$urandom, $urandom};
        r = w[$bits(ssmd_pkg::request_t) - 1:0];
        r.command = ssmd_pkg::CMD_SCAN;
        return r;
    endfunction

    function automatic ssmd_pkg::request_t rand_refresh();
        ssmd_pkg::request_t r;
        r = '0;
        r.command = ssmd_pkg::CMD_REFRESH;
        r.display_mode = 3'($urandom_range(0, 7));
        r.voltage = pick_two();
        r.temp_whole = pick_two();
        r.temp_fraction = pick_two();
        r.threshold = pick_two();
        // spread over digit counts so every blanking depth shows up
        case ($urandom_range(0, 5))
            0:       r.frequency = 17'($urandom_range(0, 9));
            1:       r.frequency = 17'($urandom_range(10, 99));
            2:       r.frequency = 17'($urandom_range(100, 999));
            3:       r.frequency = 17'($urandom_range(1000, 9999));
            4:       r.frequency = 17'($urandom_range(10000, 99999));
            default: r.frequency = 17'($urandom_range(0, 131071));
        endcase
        return r;
    endfunction

    task automatic send_request(input ssmd_pkg::request_t r, input bit pinned,
                                input ssmd_pkg::result_t want);
        int   gap;
        pin_t tag;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tag.pinned = pinned;
        tag.want = want;
        pin_q.push_back(tag);
        request <= r;
        request_valid <= 1'b1;
        do
            @(posedge clk);
        while (request_stall);
        items_sent++;
    endtask

    // checks results first, then predicts the request taken on the same edge
    always @(posedge clk)
    begin : monitor
        ssmd_pkg::result_t pred;
        ssmd_pkg::result_t want;
        pin_t              tag;
        bit                made;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (scan_expect_q.size() == 0)
                    report_mismatch("unexpected result", result.digit_enable, 8'h00);
                else
                begin
                    want = scan_expect_q.pop_front();
                    if (result.digit_enable !== want.digit_enable)
                        report_mismatch("digit_enable", result.digit_enable,
                                        want.digit_enable);
                    if (result.segment_bits !== want.segment_bits)
                        report_mismatch("segment_bits", result.segment_bits,
                                        want.segment_bits);
                end
            end
            if (request_valid && !request_stall)
            begin
                tag = '0;
                if (pin_q.size() != 0)
                    tag = pin_q.pop_front();
                made = predict_display(request, pred);
                if (made)
                    scan_expect_q.push_back(tag.pinned ? tag.want : pred);
            end
        end
    end

    initial
    begin : receiver
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    initial
    begin : stimulus
        ssmd_pkg::request_t r;
        int                 holds_done;
        int                 burst;
        rst_n = 1'b0;
        request = '0;
        request_valid = 1'b0;
        result_stall = 1'b0;
        holds_done = 0;
        for (int i = 0; i < 8; i++)
        begin
            disp_codes[i] = '0;
            disp_segs[i] = ssmd_pkg::SEG_DARK;
        end
        disp_pos = '0;

        // a full dark frame out of reset, then each mode at its extremes
        for (int i = 0; i < 8; i++)
            directed_rows.push_back(scan_row(1'b1, 8'd1 << i, ssmd_pkg::SEG_DARK));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_VOLT, 7'h7f, '0, '0, '0, '0));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_FREQ, '0, 17'h1ffff, '0, '0,
                                            '0));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_TEMP, '0, '0, 7'h7f, 7'h00,
                                            '0));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_THRESH, '0, '0, '0, '0, 7'd99));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_RCL_VOLT, 7'd0, '0, '0, '0,
                                            '0));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_RCL_FREQ, '0, 17'd0, '0, '0,
                                            '0));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_RCL_TEMP, '0, '0, 7'd0, 7'h7f,
                                            '0));
        directed_rows.push_back(scan_row(1'b0, '0, '0));
        directed_rows.push_back(refresh_row(ssmd_pkg::MODE_KEEP, 7'h7f, 17'h1ffff, 7'h7f,
                                            7'h7f, 7'h7f));
        directed_rows.push_back(scan_row(1'b0, '0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].pinned,
                         directed_rows[i].want);

        while (items_sent < RANDOM_ITEMS + directed_rows.size())
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            if (holds_done < 2 && items_sent > 250 * (holds_done + 1))
            begin
                // back the block up behind a long receiver hold
                long_hold_req = 1'b1;
                no_idle = 1'b1;
                repeat (24) send_request(rand_scan(), 1'b0, '0);
                holds_done++;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                r = rand_scan();
                r.command = 1'($urandom_range(0, 1));
                send_request(r, 1'b0, '0);
            end
            else
            begin
                send_request(rand_refresh(), 1'b0, '0);
                burst = $urandom_range(1, 10);
                repeat (burst) send_request(rand_scan(), 1'b0, '0);
            end
        end

        request_valid <= 1'b0;
        @(posedge clk);
        while (scan_expect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ssmd_pkg.sv
hdl/seven_segment_mode_display.sv
hdl/ssmd_checker.sv
tb/tb_seven_segment_mode_display.sv
